// ===== rtl/mts_pkg.sv =====
// package: shared constants, codes and controller command types for the min tracking stack
package mts_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;
  localparam int STAT_W  = 2;

  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOAD = 3'b010,
    S_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic accept;
    logic load;
  } cmd_t;

endpackage

// ===== rtl/mts_in_if.sv =====
// interface: request channel carrying push or pop beats
interface mts_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic signed [mts_pkg::DATA_W-1:0]   value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

// ===== rtl/mts_out_if.sv =====
// interface: response channel carrying top, minimum, count and status
interface mts_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mts_pkg::DATA_W-1:0]   top_value;
  logic signed [mts_pkg::DATA_W-1:0]   min_value;
  logic        [mts_pkg::COUNT_W-1:0]  entry_count;
  logic        [mts_pkg::STAT_W-1:0]   status;

  modport source (output valid, output top_value, output min_value, output entry_count,
                  output status, input ready);
  modport sink   (input valid, input top_value, input min_value, input entry_count,
                  input status, output ready);
endinterface

// ===== rtl/mts_ctrl.sv =====
// controller: sequences accept, store read-back and response presentation
module mts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_mode,
  input  logic          rsp_ready,
  output logic          req_ready,
  output logic          rsp_valid,
  output mts_pkg::cmd_t cmd
);

  mts_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mts_pkg::S_IDLE: begin
        // a pop goes through S_LOAD for the registered store read
        if (req_valid) begin
          state_next = (req_mode == mts_pkg::MODE_POP) ? mts_pkg::S_LOAD : mts_pkg::S_DONE;
        end
      end
      mts_pkg::S_LOAD: begin
        state_next = mts_pkg::S_DONE;
      end
      mts_pkg::S_DONE: begin
        if (rsp_ready) begin
          state_next = mts_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mts_pkg::S_IDLE;
      end
    endcase
  end

  assign req_ready  = (state == mts_pkg::S_IDLE);
  assign rsp_valid  = (state == mts_pkg::S_DONE);
  assign cmd.accept = req_ready && req_valid;
  assign cmd.load   = (state == mts_pkg::S_LOAD);

endmodule

// ===== rtl/mts_datapath.sv =====
// datapath: value and minimum stores, depth counters and cached top and minimum
module mts_datapath #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mts_pkg::cmd_t                       cmd,
  input  logic                                mode,
  input  logic signed [mts_pkg::DATA_W-1:0]   value,
  output logic signed [mts_pkg::DATA_W-1:0]   top_value,
  output logic signed [mts_pkg::DATA_W-1:0]   min_value,
  output logic        [mts_pkg::COUNT_W-1:0]  entry_count,
  output logic        [mts_pkg::STAT_W-1:0]   status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [mts_pkg::DATA_W-1:0] value_mem [DEPTH];
  logic signed [mts_pkg::DATA_W-1:0] min_mem   [DEPTH];

  logic [CW-1:0]                     vdepth;
  logic [CW-1:0]                     mdepth;
  logic signed [mts_pkg::DATA_W-1:0] top_reg;
  logic signed [mts_pkg::DATA_W-1:0] min_reg;
  mts_pkg::status_t                  stat;
  logic                              pop_ok;
  logic                              min_popped;
  logic signed [mts_pkg::DATA_W-1:0] rd_val;
  logic signed [mts_pkg::DATA_W-1:0] rd_min;

  logic          is_push;
  logic          is_pop;
  logic          full;
  logic          empty;
  logic          new_min;
  logic          push_ok;
  logic          pop_go;
  logic          drop_min;
  logic [AW-1:0] rd_vaddr;
  logic [AW-1:0] rd_maddr;

  assign is_push  = cmd.accept && (mode == mts_pkg::MODE_PUSH);
  assign is_pop   = cmd.accept && (mode == mts_pkg::MODE_POP);
  assign full     = (vdepth == CW'(DEPTH));
  assign empty    = (vdepth == '0);
  assign new_min  = (value <= min_reg);
  assign push_ok  = is_push && !full;
  assign pop_go   = is_pop && !empty;
  assign drop_min = (min_reg == top_reg) && (mdepth != '0);
  // entry just below the current top, read for the next cycle
  assign rd_vaddr = AW'(vdepth - CW'(2));
  assign rd_maddr = AW'(mdepth - CW'(2));

  always_ff @(posedge clk) begin
    if (push_ok) begin
      value_mem[vdepth[AW-1:0]] <= value;
      if (new_min) begin
        min_mem[mdepth[AW-1:0]] <= value;
      end
    end
    rd_val <= value_mem[rd_vaddr];
    rd_min <= min_mem[rd_maddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vdepth     <= '0;
      mdepth     <= '0;
      top_reg    <= '0;
      min_reg    <= mts_pkg::INT_MAX;
      pop_ok     <= 1'b0;
      min_popped <= 1'b0;
    end else if (cmd.accept) begin
      pop_ok     <= pop_go;
      min_popped <= pop_go && drop_min;
      if (push_ok) begin
        vdepth  <= vdepth + CW'(1);
        top_reg <= value;
        if (new_min) begin
          mdepth  <= mdepth + CW'(1);
          min_reg <= value;
        end
      end else if (pop_go) begin
        vdepth <= vdepth - CW'(1);
        if (drop_min) begin
          mdepth <= mdepth - CW'(1);
        end
      end
    end else if (cmd.load && pop_ok) begin
      top_reg <= (vdepth == '0) ? '0 : rd_val;
      if (min_popped) begin
        min_reg <= (mdepth == '0) ? mts_pkg::INT_MAX : rd_min;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (is_push && full) begin
        stat <= mts_pkg::ST_OVERFLOW;
      end else if (is_pop && empty) begin
        stat <= mts_pkg::ST_UNDERFLOW;
      end else begin
        stat <= mts_pkg::ST_OK;
      end
    end
  end

  assign top_value   = top_reg;
  assign min_value   = min_reg;
  assign entry_count = mts_pkg::COUNT_W'(vdepth);
  assign status      = stat;

endmodule

// ===== rtl/min_tracking_stack.sv =====
// top level: min tracking stack with request and response channels
// LIFO stack of signed 32-bit values that also reports the current minimum. Each request beat
// is a push or a pop and yields exactly one response beat with the top entry, the minimum, the
// entry count and a status (ok, underflow on pop of an empty stack, overflow on push when
// full). The block takes one request at a time: a push shows its response in the cycle after
// acceptance; a pop first passes through a load state because the new top and minimum come
// back through a registered read of the value and minimum stores. Once the response is taken
// the block is ready again in the next cycle. The stores need no clearing after reset: only
// entries below the current depth are ever used.
module min_tracking_stack #(
  parameter int DEPTH = 64
) (
  input logic     clk,
  input logic     rst,
  mts_in_if.sink  req,
  mts_out_if.source rsp
);

  mts_pkg::cmd_t cmd;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_mode  (req.mode),
    .rsp_ready (rsp.ready),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .cmd       (cmd)
  );

  mts_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (req.mode),
    .value       (req.value),
    .top_value   (rsp.top_value),
    .min_value   (rsp.min_value),
    .entry_count (rsp.entry_count),
    .status      (rsp.status)
  );

  // one item in flight: never ready for a request while a response is on offer
  assert property (@(posedge clk) disable iff (rst) !(req.ready && rsp.valid))
    else $error("request ready while response pending");

  // underflow leaves an empty stack
  assert property (@(posedge clk) disable iff (rst)
      rsp.valid && (rsp.status == mts_pkg::ST_UNDERFLOW) |->
      (rsp.entry_count == '0) && (rsp.top_value == '0) && (rsp.min_value == mts_pkg::INT_MAX))
    else $error("underflow response does not show an empty stack");

  // overflow only when the stack holds DEPTH entries
  assert property (@(posedge clk) disable iff (rst)
      rsp.valid && (rsp.status == mts_pkg::ST_OVERFLOW) |->
      (rsp.entry_count == mts_pkg::COUNT_W'(DEPTH)))
    else $error("overflow reported on a stack that is not full");

  // a push beat is answered in the very next cycle
  assert property (@(posedge clk) disable iff (rst)
      req.valid && req.ready && (req.mode == mts_pkg::MODE_PUSH) |=> rsp.valid)
    else $error("push response late");

  // the minimum never exceeds the top entry
  assert property (@(posedge clk) disable iff (rst)
      rsp.valid && (rsp.entry_count != '0) |-> (rsp.min_value <= rsp.top_value))
    else $error("minimum above top entry");

endmodule
